/* src/mosd_pkg.sv */
// Shared types and constants of the motion onset standard-deviation detector.
package mosd_pkg;

  // Window geometry and arithmetic widths.
  localparam int WINDOW_DEPTH = 5;
  localparam int SAMPLE_W     = 24;
  localparam int IDX_W        = $clog2(WINDOW_DEPTH);
  localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W        = SAMPLE_W + $clog2(WINDOW_DEPTH);
  localparam int PROD_W       = 2 * SUM_W;
  localparam int SUMSQ_W      = 2 * SAMPLE_W - 1 + $clog2(WINDOW_DEPTH);

  // Configuration registers.
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;
  localparam logic [CFG_W-1:0] THRESHOLD_RESET = 16'd50;
  localparam logic [CFG_W-1:0] HOLD_RESET      = 16'd10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 1'b0,
    REG_HOLD      = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_MOVING = 2'd1,
    OP_TICK   = 2'd2
  } op_e;

  // Step requested from the shared arithmetic unit.
  typedef enum logic [2:0] {
    AOP_NONE,
    AOP_CLEAR,
    AOP_SQ,
    AOP_ACC,
    AOP_SUM2,
    AOP_TSQ
  } aop_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ,
    S_ACC,
    S_SUM2,
    S_TSQ,
    S_CMP,
    S_OUT
  } state_e;

endpackage

/* src/motion_onset_stddev_detector.sv */
// Top level of the motion onset detector: sequencer, hold timer, configuration and output register.
// A transaction that skips the window test goes from idle through S_OUT into the output register,
// and the sequencer then returns to idle to take the next one. A sample that tests the window
// steps through S_SQ and S_ACC for each window entry, then S_SUM2, S_TSQ and S_CMP, before S_OUT;
// one squaring multiplier visits the window entries one after another. An output stall holds the
// sequencer in S_OUT. Reset clears the fill count, the hold and the output valid and loads the
// default threshold and hold length; window contents stay unknown.
module motion_onset_stddev_detector (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic        [1:0]                     operation_i,
  input  logic signed [mosd_pkg::SAMPLE_W-1:0]  altitude_mm_i,
  input  logic                                  altitude_valid_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  onset_o,
  output logic                                  hold_active_o,
  output logic                                  stream_off_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic        [mosd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [mosd_pkg::CFG_W-1:0]     cfg_data_i
);
  import mosd_pkg::*;

  state_e                     state_q, state_d;
  logic [IDX_W-1:0]           idx_q, idx_d;
  logic                       hold_run_q, hold_run_d;
  logic [CFG_W-1:0]           hold_rem_q, hold_rem_d;
  logic [CFG_W-1:0]           rem_dec;
  logic [CFG_W-1:0]           thresh_q, thresh_d;
  logic [CFG_W-1:0]           hold_ticks_q, hold_ticks_d;
  logic                       res_onset_q, res_onset_d;
  logic                       res_soff_q, res_soff_d;
  logic                       out_valid_q, out_valid_d;
  logic                       out_onset_q, out_onset_d;
  logic                       out_hold_q, out_hold_d;
  logic                       out_soff_q, out_soff_d;

  logic                       accept;
  logic                       is_sample;
  logic                       start_test;
  logic                       out_free;
  logic                       last_elem;
  logic                       full_next;
  logic                       moving;
  logic signed [SAMPLE_W-1:0] elem;
  aop_e                       aop;

  // The input is open only while the sequencer is idle.
  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign is_sample   = (op_e'(operation_i) == OP_SAMPLE) && altitude_valid_i;
  // A valid sample is tested only if it fills or refreshes a full window and no hold runs.
  assign start_test  = is_sample && !hold_run_q && full_next;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign last_elem   = (idx_q == IDX_W'(WINDOW_DEPTH - 1));
  assign cfg_ready_o = 1'b1;

  mosd_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && is_sample),
    .sample_i    (altitude_mm_i),
    .rd_idx_i    (idx_q),
    .elem_o      (elem),
    .full_next_o (full_next)
  );

  mosd_arith u_arith (
    .clk_i       (clk_i),
    .aop_i       (aop),
    .elem_i      (elem),
    .threshold_i (thresh_q),
    .moving_o    (moving)
  );

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = start_test ? S_SQ : S_OUT;
        end
      end
      S_SQ:   state_d = S_ACC;
      S_ACC:  state_d = last_elem ? S_SUM2 : S_SQ;
      S_SUM2: state_d = S_TSQ;
      S_TSQ:  state_d = S_CMP;
      S_CMP:  state_d = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Step issued to the arithmetic unit in each state.
  always_comb begin
    unique case (state_q)
      S_IDLE:  aop = (accept && start_test) ? AOP_CLEAR : AOP_NONE;
      S_SQ:    aop = AOP_SQ;
      S_ACC:   aop = AOP_ACC;
      S_SUM2:  aop = AOP_SUM2;
      S_TSQ:   aop = AOP_TSQ;
      default: aop = AOP_NONE;
    endcase
  end

  assign rem_dec = (hold_rem_q == '0) ? '0 : (hold_rem_q - 1'b1);

  // Hold timer, element index and the pending result.
  always_comb begin
    idx_d       = idx_q;
    hold_run_d  = hold_run_q;
    hold_rem_d  = hold_rem_q;
    res_onset_d = res_onset_q;
    res_soff_d  = res_soff_q;
    if (accept) begin
      idx_d       = '0;
      res_onset_d = 1'b0;
      res_soff_d  = 1'b0;
      unique case (op_e'(operation_i))
        OP_SAMPLE: begin
        end
        OP_MOVING: begin
          hold_run_d = 1'b1;
          hold_rem_d = hold_ticks_q;
        end
        OP_TICK: begin
          if (hold_run_q) begin
            hold_rem_d = rem_dec;
            if (rem_dec == '0) begin
              hold_run_d = 1'b0;
              res_soff_d = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
    if ((state_q == S_ACC) && !last_elem) begin
      idx_d = idx_q + 1'b1;
    end
    if ((state_q == S_CMP) && moving) begin
      hold_run_d  = 1'b1;
      hold_rem_d  = hold_ticks_q;
      res_onset_d = 1'b1;
    end
  end

  // Configuration writes must arrive only while the block is idle; the block itself does not enforce this.
  always_comb begin
    thresh_d     = thresh_q;
    hold_ticks_d = hold_ticks_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_e'(cfg_index_i))
        REG_THRESHOLD: thresh_d     = cfg_data_i;
        REG_HOLD:      hold_ticks_d = cfg_data_i;
      endcase
    end
  end

  // The output register takes the result once it is free; the sequencer then returns to idle
  // and the next transaction can be accepted on the following cycle.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_onset_d = out_onset_q;
    out_hold_d  = out_hold_q;
    out_soff_d  = out_soff_q;
    if ((state_q == S_OUT) && out_free) begin
      out_valid_d = 1'b1;
      out_onset_d = res_onset_q;
      out_hold_d  = hold_run_q;
      out_soff_d  = res_soff_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      hold_run_q   <= 1'b0;
      hold_rem_q   <= '0;
      thresh_q     <= THRESHOLD_RESET;
      hold_ticks_q <= HOLD_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      hold_run_q   <= hold_run_d;
      hold_rem_q   <= hold_rem_d;
      thresh_q     <= thresh_d;
      hold_ticks_q <= hold_ticks_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    res_onset_q <= res_onset_d;
    res_soff_q  <= res_soff_d;
    out_onset_q <= out_onset_d;
    out_hold_q  <= out_hold_d;
    out_soff_q  <= out_soff_d;
  end

  assign out_valid_o   = out_valid_q;
  assign onset_o       = out_onset_q;
  assign hold_active_o = out_hold_q;
  assign stream_off_o  = out_soff_q;

endmodule

/* src/mosd_window.sv */
// Sliding window of altitude samples with its fill counter.
module mosd_window (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push_i,
  input  logic signed [mosd_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic        [mosd_pkg::IDX_W-1:0]     rd_idx_i,
  output logic signed [mosd_pkg::SAMPLE_W-1:0]  elem_o,
  output logic                                  full_next_o
);
  import mosd_pkg::*;

  logic signed [SAMPLE_W-1:0] win_q [WINDOW_DEPTH];
  logic        [FILL_W-1:0]   fill_q, fill_d;

  // New samples enter at the top; once full, the window holds the newest samples.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[WINDOW_DEPTH-1] <= sample_i;
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (push_i && (fill_q != FILL_W'(WINDOW_DEPTH))) begin
      fill_d = fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  assign elem_o      = win_q[rd_idx_i];
  assign full_next_o = (fill_q >= FILL_W'(WINDOW_DEPTH - 1));

endmodule

/* src/mosd_arith.sv */
// Shared squaring unit with the sum, sum-of-squares and deviation compare registers.
module mosd_arith (
  input  logic                                  clk_i,
  input  mosd_pkg::aop_e                        aop_i,
  input  logic signed [mosd_pkg::SAMPLE_W-1:0]  elem_i,
  input  logic        [mosd_pkg::CFG_W-1:0]     threshold_i,
  output logic                                  moving_o
);
  import mosd_pkg::*;

  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic        [SUMSQ_W-1:0]  sumsq_q, sumsq_d;
  logic        [PROD_W-1:0]   prod_q, prod_d;
  logic        [PROD_W-1:0]   lhs_q, lhs_d;
  logic        [SAMPLE_W-1:0] elem_abs;
  logic        [SUM_W-1:0]    sum_abs;
  logic        [SUM_W-1:0]    mul_a;
  logic        [PROD_W-1:0]   mul_p;
  logic        [PROD_W-1:0]   rhs;

  assign elem_abs = elem_i[SAMPLE_W-1] ? (~elem_i + 1'b1) : elem_i;
  assign sum_abs  = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;

  // The one multiplier squares whatever operand the current step selects.
  always_comb begin
    case (aop_i)
      AOP_SQ:   mul_a = SUM_W'(elem_abs);
      AOP_SUM2: mul_a = sum_abs;
      AOP_TSQ:  mul_a = SUM_W'(threshold_i);
      default:  mul_a = '0;
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_a);

  always_comb begin
    sum_d   = sum_q;
    sumsq_d = sumsq_q;
    prod_d  = prod_q;
    lhs_d   = lhs_q;
    case (aop_i)
      AOP_CLEAR: begin
        sum_d   = '0;
        sumsq_d = '0;
      end
      AOP_SQ: begin
        prod_d = mul_p;
        sum_d  = sum_q + SUM_W'(elem_i);
      end
      AOP_ACC: begin
        sumsq_d = sumsq_q + prod_q[SUMSQ_W-1:0];
      end
      AOP_SUM2: begin
        prod_d = mul_p;
        lhs_d  = PROD_W'(sumsq_q) * PROD_W'(WINDOW_DEPTH);
      end
      AOP_TSQ: begin
        prod_d = mul_p;
        lhs_d  = (lhs_q >= prod_q) ? (lhs_q - prod_q) : '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    sum_q   <= sum_d;
    sumsq_q <= sumsq_d;
    prod_q  <= prod_d;
    lhs_q   <= lhs_d;
  end

  // After the threshold step, prod_q holds the squared threshold.
  assign rhs      = PROD_W'(prod_q[2*CFG_W-1:0]) * PROD_W'(WINDOW_DEPTH * WINDOW_DEPTH);
  assign moving_o = (lhs_q > rhs);

endmodule

/* tb/motion_onset_stddev_detector_tb.sv */
// Self-checking testbench of the motion onset standard-deviation detector.
module motion_onset_stddev_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mosd_pkg::*;

  // The one operation code that the package leaves unnamed; the block must ignore it.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // The limit lies well above the slowest correct run, in which each transaction may wait at the
  // sender, in the block and at the receiver.
  localparam int CYCLE_LIMIT  = 400000;
  // Cycles allowed after the last result, a little more than one full window test.
  localparam int DRAIN_CYCLES = 2 * WINDOW_DEPTH + 10;

  localparam longint ALT_MAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint ALT_MIN = -ALT_MAX - 1;

  // One result transaction of the block.
  typedef struct packed {
    logic onset;
    logic hold_active;
    logic stream_off;
  } detector_flags_t;

  // Every input of the block has a known value from time zero.
  logic                         clk_i            = 1'b0;
  logic                         rst_ni           = 1'b0;
  logic                         in_valid_i       = 1'b0;
  logic                         in_stall_o;
  logic [1:0]                   operation_i      = OP_SAMPLE;
  logic signed [SAMPLE_W-1:0]   altitude_mm_i    = '0;
  logic                         altitude_valid_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_stall_i      = 1'b0;
  logic                         onset_o;
  logic                         hold_active_o;
  logic                         stream_off_o;
  logic                         cfg_valid_i      = 1'b0;
  logic                         cfg_ready_o;
  logic [CFG_IDX_W-1:0]         cfg_index_i      = REG_THRESHOLD;
  logic [CFG_W-1:0]             cfg_data_i       = '0;

  motion_onset_stddev_detector dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .altitude_mm_i    (altitude_mm_i),
    .altitude_valid_i (altitude_valid_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .onset_o          (onset_o),
    .hold_active_o    (hold_active_o),
    .stream_off_o     (stream_off_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // Free-running 4 ns clock.
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Our own copy of the detector state and of its two registers, at reset values.
  logic signed [SAMPLE_W-1:0] win_samples [WINDOW_DEPTH];
  int                         win_fill  = 0;
  logic                       hold_on   = 1'b0;
  logic [CFG_W-1:0]           hold_left = '0;
  logic [CFG_W-1:0]           thr_mm    = THRESHOLD_RESET;
  logic [CFG_W-1:0]           hold_len  = HOLD_RESET;

  // Flags that the block owes us, oldest first.
  detector_flags_t expected_flags [$];

  int   errors = 0;
  int   cycles = 0;
  int   rx_wait = 0;
  // When clear, neither side idles; the random phases toggle it to get stretches of full rate.
  logic idle_on = 1'b1;
  detector_flags_t want;

  // Number of cycles a side holds off before its next transaction.
  function automatic int draw_wait();
    return idle_on ? int'($urandom_range(0, 6)) : 0;
  endfunction

  // Exact integer form of "population deviation exceeds the threshold":
  // N*sum(x^2) - sum(x)^2 > N^2*threshold^2. All terms fit a signed 64-bit value.
  function automatic logic window_is_moving();
    longint x;
    longint total = 0;
    longint total_sq = 0;
    longint spread;
    longint limit;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      x = longint'(win_samples[i]);
      total += x;
      total_sq += x * x;
    end
    spread = longint'(WINDOW_DEPTH) * total_sq - total * total;
    if (spread < 0) begin
      spread = 0;
    end
    limit = longint'(WINDOW_DEPTH) * longint'(WINDOW_DEPTH) * longint'(thr_mm) * longint'(thr_mm);
    return spread > limit;
  endfunction

  // Advances our copy of the state by one input transaction and returns the flags it causes.
  function automatic detector_flags_t predict_flags(input logic [1:0] op,
                                                    input logic signed [SAMPLE_W-1:0] alt,
                                                    input logic alt_ok);
    detector_flags_t flags;
    flags = '0;
    case (op)
      OP_SAMPLE: begin
        // Invalid samples are neither stored nor tested.
        if (alt_ok) begin
          if (win_fill < WINDOW_DEPTH) begin
            win_samples[win_fill] = alt;
            win_fill++;
          end else begin
            for (int i = 1; i < WINDOW_DEPTH; i++) begin
              win_samples[i-1] = win_samples[i];
            end
            win_samples[WINDOW_DEPTH-1] = alt;
          end
          // While a hold runs the sample is stored but never tested.
          if (!hold_on && win_fill >= WINDOW_DEPTH && window_is_moving()) begin
            hold_on     = 1'b1;
            hold_left   = hold_len;
            flags.onset = 1'b1;
          end
        end
      end
      OP_MOVING: begin
        // A tracker report restarts the hold without raising onset.
        hold_on   = 1'b1;
        hold_left = hold_len;
      end
      OP_TICK: begin
        // A hold length of zero ends at the very next tick, just like a length of one.
        if (hold_on) begin
          if (hold_left > 0) begin
            hold_left--;
          end
          if (hold_left == 0) begin
            hold_on          = 1'b0;
            flags.stream_off = 1'b1;
          end
        end
      end
      default: begin
        // The unused code leaves all state alone.
      end
    endcase
    flags.hold_active = hold_on;
    return flags;
  endfunction

  // Sends one input transaction after a random hold-off and records what it must produce.
  // Valid stays high after acceptance, so back-to-back transactions keep it high throughout.
  task automatic send_input(input logic [1:0] op, input logic signed [SAMPLE_W-1:0] alt,
                            input logic alt_ok);
    int gap;
    gap = draw_wait();
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    operation_i      <= op;
    altitude_mm_i    <= alt;
    altitude_valid_i <= alt_ok;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    expected_flags.push_back(predict_flags(op, alt, alt_ok));
  endtask

  // Stops sending and waits until every result that is owed has been taken.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (expected_flags.size() != 0);
  endtask

  // Writes one register; the caller lowers the write valid after the last write.
  task automatic write_reg(input reg_e index, input logic [CFG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    if (index == REG_THRESHOLD) begin
      thr_mm = data;
    end else begin
      hold_len = data;
    end
  endtask

  // Registers are to change only while the block is idle, so drain first.
  task automatic apply_settings(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] hold);
    drain_results();
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_HOLD, hold);
    cfg_valid_i <= 1'b0;
  endtask

  // Directed pass over the special cases at the reset settings, then the field extremes.
  task automatic test_special_cases();
    // A tick with no hold running does nothing.
    send_input(OP_TICK, '0, 1'b0);
    // The unused operation code is ignored.
    send_input(OP_UNUSED, 24'h7FFFFF, 1'b1);
    // An invalid sample is not stored.
    send_input(OP_SAMPLE, 24'h800000, 1'b0);
    // Fill the window with the extremes; the fifth sample tests it and starts the hold.
    send_input(OP_SAMPLE, 24'h800000, 1'b1);
    send_input(OP_SAMPLE, 24'h7FFFFF, 1'b1);
    send_input(OP_SAMPLE, 24'h000000, 1'b1);
    send_input(OP_SAMPLE, 24'hFFFFFF, 1'b1);
    send_input(OP_SAMPLE, 24'h000001, 1'b1);
    // During the hold samples are stored but never tested.
    send_input(OP_SAMPLE, 24'h7FFFFF, 1'b1);
    // A tracker report restarts the hold and leaves onset low.
    send_input(OP_MOVING, 24'h555555, 1'b1);
    send_input(OP_TICK, 24'hAAAAAA, 1'b1);
  endtask

  // A hold length of zero, a zero threshold and the largest threshold.
  task automatic test_hold_length_zero();
    apply_settings(16'd0, 16'd0);
    send_input(OP_MOVING, '0, 1'b0);
    send_input(OP_TICK, '0, 1'b0);
    send_input(OP_TICK, '0, 1'b0);
    // The first of these tests a mixed window and fires; the rest fall inside the hold.
    repeat (5) begin
      send_input(OP_SAMPLE, 24'd1234, 1'b1);
    end
    send_input(OP_TICK, '0, 1'b0);
    // A window of equal samples has no spread, which a zero threshold does not exceed.
    send_input(OP_SAMPLE, 24'd1234, 1'b1);
    apply_settings(16'hFFFF, 16'd1);
    send_input(OP_SAMPLE, 24'h800000, 1'b1);
    send_input(OP_TICK, '0, 1'b1);
  endtask

  // Random traffic under one setting. Most transactions are valid samples scattered around a
  // drifting base, with a spread drawn around the threshold, so onsets come and go; ticks run
  // the holds down, and tracker reports, invalid samples and the unused code are mixed in.
  task automatic test_random_phase(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] hold,
                                   input int count);
    longint base;
    longint amp;
    longint v;
    int     pick;
    apply_settings(thr, hold);
    base = longint'($urandom_range(0, (1 << SAMPLE_W) - 1)) + ALT_MIN;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 59) == 0) begin
        idle_on = ~idle_on;
      end
      // Now and then the sender holds off until the block has nothing left to deliver.
      if ($urandom_range(0, 149) == 0) begin
        drain_results();
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        case ($urandom_range(0, 4))
          0:       amp = 0;
          1:       amp = longint'(thr) / 2;
          2:       amp = longint'(thr);
          3:       amp = 2 * longint'(thr);
          default: amp = 4 * longint'(thr);
        endcase
        amp += $urandom_range(0, 3);
        if ($urandom_range(0, 19) == 0) begin
          v = longint'($urandom_range(0, (1 << SAMPLE_W) - 1)) + ALT_MIN;
        end else begin
          v = base + longint'($urandom_range(0, 32'(2 * amp))) - amp;
        end
        if (v > ALT_MAX) begin
          v = ALT_MAX;
        end else if (v < ALT_MIN) begin
          v = ALT_MIN;
        end
        send_input(OP_SAMPLE, SAMPLE_W'(v), 1'b1);
        if ($urandom_range(0, 9) == 0) begin
          base = base + longint'($urandom_range(0, 4 * 32'(thr) + 8)) - 2 * longint'(thr) - 4;
        end
      end else if (pick < 62) begin
        send_input(OP_SAMPLE, SAMPLE_W'($urandom), 1'b0);
      end else if (pick < 88) begin
        send_input(OP_TICK, SAMPLE_W'($urandom), 1'($urandom));
      end else if (pick < 94) begin
        send_input(OP_MOVING, SAMPLE_W'($urandom), 1'($urandom));
      end else begin
        send_input(OP_UNUSED, SAMPLE_W'($urandom), 1'($urandom));
      end
    end
  endtask

  // Result side: every accepted result is compared with the oldest expectation, then the
  // receiver draws how long it stalls before taking the next one.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_flags.size() == 0) begin
        $display("%0t: result with nothing expected: onset %0b hold_active %0b stream_off %0b",
                 $time, onset_o, hold_active_o, stream_off_o);
        errors++;
      end else begin
        want = expected_flags.pop_front();
        if (onset_o !== want.onset) begin
          $display("%0t: onset mismatch, expected %0b, actual %0b", $time, want.onset, onset_o);
          errors++;
        end
        if (hold_active_o !== want.hold_active) begin
          $display("%0t: hold_active mismatch, expected %0b, actual %0b",
                   $time, want.hold_active, hold_active_o);
          errors++;
        end
        if (stream_off_o !== want.stream_off) begin
          $display("%0t: stream_off mismatch, expected %0b, actual %0b",
                   $time, want.stream_off, stream_off_o);
          errors++;
        end
      end
      rx_wait = draw_wait();
    end
    if (rx_wait > 0) begin
      out_stall_i <= 1'b1;
      rx_wait--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog: a hung handshake or a missing result ends the run as a failure.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Reset once, run the tests in turn, let the block settle and report.
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_cases();
    test_hold_length_zero();
    test_random_phase(16'hFFFF, 16'hFFFF, 150);
    test_random_phase(16'd0, 16'd1, 300);
    test_random_phase(16'd50, 16'd20, 300);
    test_random_phase(16'd300, 16'd7, 300);
    test_random_phase(16'd12, 16'd3, 300);
    test_random_phase(CFG_W'($urandom_range(0, 400)), CFG_W'($urandom_range(1, 40)), 300);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
